FILE: rtl/sflc_pkg.sv
// Shared types and constants of the serial flash loader command engine.
package sflc_pkg;

  typedef enum logic [1:0] {
    ACT_TX    = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_ERASE = 2'd2,
    ACT_START = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_ADDR_HI = 3'd1,
    PH_ADDR_LO = 3'd2,
    PH_LEN     = 3'd3,
    PH_DATA    = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    SQ_IDLE     = 3'd0,
    SQ_SINGLE   = 3'd1,
    SQ_FLUSH_RD = 3'd2,
    SQ_FLUSH_EM = 3'd3,
    SQ_ERASE    = 3'd4,
    SQ_ECHO     = 3'd5,
    SQ_CKSUM    = 3'd6
  } seq_e;

  localparam logic [7:0] CH_ADDR  = 8'h41;  // 'A'
  localparam logic [7:0] CH_LEN   = 8'h4C;  // 'L'
  localparam logic [7:0] CH_DATA  = 8'h44;  // 'D'
  localparam logic [7:0] CH_EXEC  = 8'h45;  // 'E'
  localparam logic [7:0] CH_ERROR = 8'h3F;  // '?'

  localparam logic [31:0] TIMEOUT_RESET = 32'd16000000;

endpackage

FILE: rtl/sflc_page_buf.sv
// Page buffer: byte-write, row-read synchronous memory with per-byte valid flags.
module sflc_page_buf #(
  parameter int PAGE_BYTES = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [$clog2(PAGE_BYTES)-1:0]        wr_addr_i,
  input  logic [7:0]                           wr_data_i,
  input  logic                                 rd_en_i,
  input  logic [((PAGE_BYTES/8 > 1) ? $clog2(PAGE_BYTES/8) : 1)-1:0] rd_row_i,
  output logic [63:0]                          rd_data_o
);

  localparam int ROWS  = PAGE_BYTES / 8;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [63:0]           mem_q [ROWS];
  logic [PAGE_BYTES-1:0] vld_q;
  logic [63:0]           rd_data_q;
  logic [7:0]            rd_vld_q;
  logic [ROW_W-1:0]      wr_row;
  logic [2:0]            wr_lane;

  assign wr_row  = ROW_W'(wr_addr_i >> 3);
  assign wr_lane = wr_addr_i[2:0];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row][8*wr_lane +: 8] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  // Bytes never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= '0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[8*rd_row_i +: 8];
      end
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      rd_data_o[8*b +: 8] = rd_vld_q[b] ? rd_data_q[8*b +: 8] : 8'h00;
    end
  end

endmodule

FILE: rtl/serial_flash_loader_command_engine_top.sv
// Top level of the serial flash loader command engine.
// Takes one input transaction (received byte or tick) at a time and emits its
// results through a single output register; in_ready_o is high only while the
// sequencer is idle. A command letter or tick holds the sequencer until every
// result it causes is loaded into the output register. A page flush is bound
// by the single read port of the page buffer: each 8-byte fill chunk takes a
// row read (SQ_FLUSH_RD), then an output load (SQ_FLUSH_EM). The last data
// byte echoes and then flushes its page, and a last byte that also crosses
// into a new page flushes twice. The page buffer holds per-byte valid flops
// cleared at reset, so no clearing pass follows reset. Stalls on out_ready_i
// simply hold the sequencer.
module serial_flash_loader_command_engine_top #(
  parameter int PAGE_BYTES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [15:0] flash_address_o,
  output logic [63:0] payload_o,
  output logic        last_o
);
  import sflc_pkg::*;

  localparam int ROWS  = PAGE_BYTES / 8;
  localparam int IDX_W = $clog2(PAGE_BYTES);
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [15:0] BASE_MASK = ~16'(PAGE_BYTES - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  seq_e   seq_q, seq_d;
  phase_e phase_q, phase_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cksum_q, cksum_d;
  logic [15:0] waddr_q, waddr_d;
  logic [7:0]  left_q, left_d;
  logic [15:0] pbase_q, pbase_d;
  logic [15:0] fbase_q, fbase_d;
  logic [31:0] ticks_q, ticks_d;
  logic [31:0] timeout_q;
  logic [ROW_W-1:0] chunk_q, chunk_d;
  logic        pass2_q, pass2_d;
  logic        final_q, final_d;
  logic [7:0]  byte_q, byte_d;
  action_e     sgl_act_q, sgl_act_d;
  logic [7:0]  sgl_byte_q, sgl_byte_d;

  logic        out_valid_q;
  action_e     act_q;
  logic [15:0] fadr_q;
  logic [63:0] pay_q;
  logic        last_q;

  logic        accept, load;
  logic        live, tick_hit, page_chg;
  logic [31:0] ticks_inc;
  logic        emit;
  action_e     e_act;
  logic [15:0] e_adr;
  logic [63:0] e_pay;
  logic        e_last;
  logic        mem_we, mem_re;
  logic [63:0] mem_rdata;

  assign in_ready_o = (seq_q == SQ_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = !out_valid_q || out_ready_i;
  assign live       = accept && (phase_q != PH_DONE);
  assign ticks_inc  = (ticks_q != 32'hFFFF_FFFF) ? ticks_q + 32'd1 : ticks_q;
  assign tick_hit   = (phase_q == PH_WAIT) && (ticks_inc >= timeout_q);
  assign page_chg   = (waddr_q & BASE_MASK) != pbase_q;

  sflc_page_buf #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_page_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (waddr_q[IDX_W-1:0]),
    .wr_data_i (byte_q),
    .rd_en_i   (mem_re),
    .rd_row_i  (chunk_q),
    .rd_data_o (mem_rdata)
  );

  // Sequencer next state.
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SQ_IDLE: begin
        if (live) begin
          if (kind_i) begin
            if (tick_hit) seq_d = SQ_SINGLE;
          end else begin
            case (phase_q)
              PH_WAIT: begin
                if (rx_byte_i == CH_DATA) begin
                  if (len_q == 8'd0) seq_d = SQ_FLUSH_RD;
                end else if (rx_byte_i != CH_ADDR && rx_byte_i != CH_LEN) begin
                  seq_d = SQ_SINGLE;
                end
              end
              PH_DATA: seq_d = page_chg ? SQ_FLUSH_RD : SQ_ECHO;
              default: seq_d = SQ_SINGLE;
            endcase
          end
        end
      end
      SQ_SINGLE:   if (load) seq_d = SQ_IDLE;
      SQ_FLUSH_RD: seq_d = SQ_FLUSH_EM;
      SQ_FLUSH_EM: if (load) seq_d = (chunk_q == LAST_ROW) ? SQ_ERASE : SQ_FLUSH_RD;
      SQ_ERASE:    if (load) seq_d = pass2_q ? SQ_CKSUM : SQ_ECHO;
      SQ_ECHO:     if (load) seq_d = final_q ? SQ_FLUSH_RD : SQ_IDLE;
      SQ_CKSUM:    if (load) seq_d = SQ_IDLE;
      default:     seq_d = SQ_IDLE;
    endcase
  end

  // Sequencer outputs: result to load and page buffer control.
  always_comb begin
    emit   = 1'b0;
    e_act  = ACT_TX;
    e_adr  = 16'h0000;
    e_pay  = 64'd0;
    e_last = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    case (seq_q)
      SQ_SINGLE: begin
        emit   = 1'b1;
        e_act  = sgl_act_q;
        e_pay  = {56'd0, sgl_byte_q};
        e_last = 1'b1;
      end
      SQ_FLUSH_RD: mem_re = 1'b1;
      SQ_FLUSH_EM: begin
        emit  = 1'b1;
        e_act = ACT_FILL;
        e_adr = fbase_q + (16'(chunk_q) << 3);
        e_pay = mem_rdata;
      end
      SQ_ERASE: begin
        emit  = 1'b1;
        e_act = ACT_ERASE;
        e_adr = fbase_q;
      end
      SQ_ECHO: begin
        emit   = 1'b1;
        e_pay  = {56'd0, byte_q};
        e_last = !final_q;
        mem_we = load;
      end
      SQ_CKSUM: begin
        emit   = 1'b1;
        e_pay  = {56'd0, 8'd0 - cksum_q};
        e_last = 1'b1;
      end
      default: ;
    endcase
  end

  // Protocol state updates.
  always_comb begin
    phase_d    = phase_q;
    addr_d     = addr_q;
    len_d      = len_q;
    cksum_d    = cksum_q;
    waddr_d    = waddr_q;
    left_d     = left_q;
    pbase_d    = pbase_q;
    fbase_d    = fbase_q;
    ticks_d    = ticks_q;
    chunk_d    = chunk_q;
    pass2_d    = pass2_q;
    final_d    = final_q;
    byte_d     = byte_q;
    sgl_act_d  = sgl_act_q;
    sgl_byte_d = sgl_byte_q;
    case (seq_q)
      SQ_IDLE: begin
        if (live) begin
          if (kind_i) begin
            if (phase_q == PH_WAIT) begin
              ticks_d = ticks_inc;
              if (tick_hit) begin
                phase_d    = PH_DONE;
                sgl_act_d  = ACT_START;
                sgl_byte_d = 8'h00;
              end
            end
          end else begin
            case (phase_q)
              PH_WAIT: begin
                if (rx_byte_i == CH_ADDR) begin
                  phase_d = PH_ADDR_HI;
                end else if (rx_byte_i == CH_LEN) begin
                  phase_d = PH_LEN;
                end else if (rx_byte_i == CH_DATA) begin
                  waddr_d = addr_q;
                  pbase_d = addr_q & BASE_MASK;
                  left_d  = len_q;
                  if (len_q == 8'd0) begin
                    fbase_d = addr_q & BASE_MASK;
                    pass2_d = 1'b1;
                    chunk_d = '0;
                  end else begin
                    phase_d = PH_DATA;
                  end
                end else if (rx_byte_i == CH_EXEC) begin
                  phase_d    = PH_DONE;
                  sgl_act_d  = ACT_START;
                  sgl_byte_d = 8'h00;
                end else begin
                  sgl_act_d  = ACT_TX;
                  sgl_byte_d = CH_ERROR;
                  cksum_d    = 8'h00;
                  ticks_d    = 32'd0;
                end
              end
              PH_ADDR_HI: begin
                addr_d     = {rx_byte_i, 8'h00};
                cksum_d    = cksum_q + rx_byte_i;
                sgl_act_d  = ACT_TX;
                sgl_byte_d = rx_byte_i;
                phase_d    = PH_ADDR_LO;
              end
              PH_ADDR_LO: begin
                addr_d     = {addr_q[15:8], rx_byte_i};
                cksum_d    = cksum_q + rx_byte_i;
                sgl_act_d  = ACT_TX;
                sgl_byte_d = rx_byte_i;
                phase_d    = PH_WAIT;
              end
              PH_LEN: begin
                len_d      = rx_byte_i;
                cksum_d    = cksum_q + rx_byte_i;
                sgl_act_d  = ACT_TX;
                sgl_byte_d = rx_byte_i;
                phase_d    = PH_WAIT;
              end
              PH_DATA: begin
                byte_d  = rx_byte_i;
                cksum_d = cksum_q + rx_byte_i;
                final_d = (left_q == 8'd1);
                left_d  = left_q - 8'd1;
                if (page_chg) begin
                  // Flush the old page before the byte lands in the buffer.
                  fbase_d = pbase_q;
                  pbase_d = waddr_q & BASE_MASK;
                  pass2_d = 1'b0;
                  chunk_d = '0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      SQ_FLUSH_EM: begin
        if (load && chunk_q != LAST_ROW) chunk_d = chunk_q + ROW_W'(1);
      end
      SQ_ECHO: begin
        if (load) begin
          waddr_d = waddr_q + 16'd1;
          if (final_q) begin
            phase_d = PH_WAIT;
            fbase_d = pbase_q;
            pass2_d = 1'b1;
            chunk_d = '0;
          end
        end
      end
      SQ_CKSUM: begin
        if (load) cksum_d = 8'h00;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SQ_IDLE;
      phase_q     <= PH_WAIT;
      addr_q      <= 16'h0000;
      len_q       <= 8'h00;
      cksum_q     <= 8'h00;
      waddr_q     <= 16'h0000;
      left_q      <= 8'h00;
      pbase_q     <= 16'hFFFF;
      ticks_q     <= 32'd0;
      timeout_q   <= TIMEOUT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      seq_q   <= seq_d;
      phase_q <= phase_d;
      addr_q  <= addr_d;
      len_q   <= len_d;
      cksum_q <= cksum_d;
      waddr_q <= waddr_d;
      left_q  <= left_d;
      pbase_q <= pbase_d;
      ticks_q <= ticks_d;
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (emit && load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sequencer scratch and output payload.
  always_ff @(posedge clk_i) begin
    fbase_q    <= fbase_d;
    chunk_q    <= chunk_d;
    pass2_q    <= pass2_d;
    final_q    <= final_d;
    byte_q     <= byte_d;
    sgl_act_q  <= sgl_act_d;
    sgl_byte_q <= sgl_byte_d;
    if (emit && load) begin
      act_q  <= e_act;
      fadr_q <= e_adr;
      pay_q  <= e_pay;
      last_q <= e_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = act_q;
  assign flash_address_o = fadr_q;
  assign payload_o       = pay_q;
  assign last_o          = last_q;

endmodule
